// ----- sv/awm_pkg.sv -----
// Shared types and constants for the anagram window matcher.
// Holds the action codes, the stage control struct and the result struct.
// Depends on nothing; every other file of the block imports it.
package awm_pkg;

    localparam int SYMBOL_W = 8;
    localparam int ACTION_W = 2;
    localparam int RESULT_TOTAL_W = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_TEXT    = 2'd2
    } t_action;

    typedef struct packed {
        logic valid;
        logic clear;
        logic pat_add;
        logic pat_full;
        logic txt_add;
        logic evict;
        logic win_full;
    } t_item_ctl;

    typedef struct packed {
        logic                      match;
        logic [RESULT_TOTAL_W-1:0] match_total;
        logic                      pattern_full;
    } t_result;

endpackage

// ----- sv/anagram_window_matcher_core.sv -----
// Top level of the anagram window matcher: counts text windows that are anagrams
// of a loaded pattern. Depends on awm_pkg, awm_front, awm_hist and awm_outq.
//
// Input channel (i_valid, o_ready, i_action, i_symbol): a clear, a pattern byte or a
// text byte per transfer. Output channel (o_valid, i_ready, o_match, o_match_total,
// o_pattern_full): exactly one result per input transfer, in order.
// Each result passes the front stage, the histogram stage and the result queue.
// Throughput is one item per cycle while o_ready is high: each text byte does its
// entry and exit count updates in one pass through two count memories, each with
// two read ports and one write port, with the previous write forwarded.
// Up to four items may be in flight; the result queue holds them all, so input
// transfers continue while a finished result waits for the receiver.
// When the receiver stalls, the queue fills and o_ready drops once four items are in
// flight; it rises again as results are taken.
// Reset (synchronous, active low) empties the pipeline and queue and clears the
// pattern, the window and the match total at once; the block takes input once reset
// is released. A clear clears pattern, window and total in order with the stream.
module anagram_window_matcher_core
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int ALPHABET_SIZE = 256,
    parameter int TOTAL_WIDTH   = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic [SYMBOL_W-1:0]       i_symbol,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_match,
    output logic [RESULT_TOTAL_W-1:0] o_match_total,
    output logic                      o_pattern_full
);

    localparam int BIN_W = $clog2(ALPHABET_SIZE);

    logic             take;
    t_item_ctl        s1_ctl;
    logic [BIN_W-1:0] s1_bin;
    logic [BIN_W-1:0] s1_tail_sym;
    logic             res_push;
    t_result          res;
    t_result          q_res;

    assign take = i_valid && o_ready;

    awm_front #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_action   (i_action),
        .i_symbol   (i_symbol),
        .o_ctl      (s1_ctl),
        .o_bin      (s1_bin),
        .o_tail_sym (s1_tail_sym)
    );

    awm_hist #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .TOTAL_WIDTH   (TOTAL_WIDTH)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s1_ctl),
        .i_bin      (s1_bin),
        .i_tail_sym (s1_tail_sym),
        .o_push     (res_push),
        .o_result   (res)
    );

    awm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_push      (res_push),
        .i_result    (res),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_result    (q_res)
    );

    assign o_match        = q_res.match;
    assign o_match_total  = q_res.match_total;
    assign o_pattern_full = q_res.pattern_full;

`ifndef SYNTHESIS
    a_take_reaches_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> s1_ctl.valid)
        else $error("Accepted transfer did not enter the first stage.");

    a_stage_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_ctl.valid |=> res_push)
        else $error("First stage item did not produce a result.");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !(res.match && res.pattern_full))
        else $error("Result flags both a match and a dropped pattern byte.");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && s1_ctl.valid && s1_ctl.clear) |=> (res.match_total == '0))
        else $error("Clear did not zero the match total.");
`endif

endmodule

// ----- sv/awm_front.sv -----
// Input stage of the anagram window matcher: pattern length, window fill and ring head.
// Holds the window ring memory and registers each accepted item with its control flags.
// Depends on awm_pkg.
module awm_front
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  logic [ACTION_W-1:0]              i_action,
    input  logic [SYMBOL_W-1:0]              i_symbol,
    output t_item_ctl                        o_ctl,
    output logic [$clog2(ALPHABET_SIZE)-1:0] o_bin,
    output logic [$clog2(ALPHABET_SIZE)-1:0] o_tail_sym
);

    localparam int BIN_W  = $clog2(ALPHABET_SIZE);
    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int HEAD_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SUM_W  = PLEN_W + 1;
    localparam int SYM_XW = SYMBOL_W + 1;

    logic [BIN_W-1:0]  r_ring [MAX_PATTERN];
    logic [PLEN_W-1:0] r_plen, n_plen;
    logic [PLEN_W-1:0] r_fill, n_fill;
    logic [HEAD_W-1:0] r_head, n_head;
    t_item_ctl         r_s1_ctl;
    logic [BIN_W-1:0]  r_s1_bin;
    logic [BIN_W-1:0]  r_tail_sym;

    t_item_ctl         item_ctl;
    logic [BIN_W-1:0]  bin;
    logic [PLEN_W-1:0] fill_inc;
    logic [SUM_W-1:0]  head_x;
    logic [SUM_W-1:0]  fill_x;
    logic [SUM_W-1:0]  tail_x;
    logic [HEAD_W-1:0] tail_addr;
    logic [HEAD_W-1:0] head_inc;
    logic              ring_we;

    always_comb begin
        if ({1'b0, i_symbol} >= SYM_XW'(ALPHABET_SIZE)) begin
            bin = BIN_W'(ALPHABET_SIZE - 1);
        end else begin
            bin = BIN_W'(i_symbol);
        end
    end

    always_comb begin
        head_x = SUM_W'(r_head);
        fill_x = SUM_W'(r_fill);
        if (head_x >= fill_x) begin
            tail_x = head_x - fill_x;
        end else begin
            tail_x = head_x + SUM_W'(MAX_PATTERN) - fill_x;
        end
        tail_addr = HEAD_W'(tail_x);
        if (r_head == HEAD_W'(MAX_PATTERN - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_head + HEAD_W'(1);
        end
        fill_inc = r_fill + PLEN_W'(1);
    end

    always_comb begin
        item_ctl       = '0;
        item_ctl.valid = i_take;
        n_plen         = r_plen;
        n_fill         = r_fill;
        n_head         = r_head;
        ring_we        = 1'b0;
        case (t_action'(i_action))
            ACT_CLEAR: begin
                item_ctl.clear = 1'b1;
                n_plen         = '0;
                n_fill         = '0;
                n_head         = '0;
            end
            ACT_PATTERN: begin
                if (r_plen >= PLEN_W'(MAX_PATTERN)) begin
                    item_ctl.pat_full = 1'b1;
                end else begin
                    item_ctl.pat_add = 1'b1;
                    n_plen           = r_plen + PLEN_W'(1);
                end
            end
            ACT_TEXT: begin
                if (r_plen != '0) begin
                    item_ctl.txt_add = 1'b1;
                    ring_we          = 1'b1;
                    n_head           = head_inc;
                    if (r_fill == r_plen) begin
                        item_ctl.evict    = 1'b1;
                        item_ctl.win_full = 1'b1;
                    end else begin
                        n_fill            = fill_inc;
                        item_ctl.win_full = (fill_inc == r_plen);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen   <= '0;
            r_fill   <= '0;
            r_head   <= '0;
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= i_take ? item_ctl : '0;
            if (i_take) begin
                r_plen <= n_plen;
                r_fill <= n_fill;
                r_head <= n_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_bin   <= bin;
        r_tail_sym <= r_ring[tail_addr];
        if (i_take && ring_we) begin
            r_ring[r_head] <= bin;
        end
    end

    assign o_ctl      = r_s1_ctl;
    assign o_bin      = r_s1_bin;
    assign o_tail_sym = r_tail_sym;

endmodule

// ----- sv/awm_hist.sv -----
// Histogram stage of the anagram window matcher: entry and exit count memories,
// the mismatched bin count, the saturating match total and the result of each item.
// Depends on awm_pkg.
module awm_hist
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int ALPHABET_SIZE = 256,
    parameter int TOTAL_WIDTH   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_item_ctl                        i_ctl,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] i_bin,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] i_tail_sym,
    output logic                             o_push,
    output t_result                          o_result
);

    localparam int BIN_W  = $clog2(ALPHABET_SIZE);
    localparam int DIFF_W = $clog2(MAX_PATTERN + 1);
    localparam int MM_W   = $clog2(ALPHABET_SIZE + 1);

    // The plus memory counts text bytes entering each bin; the minus memory counts
    // pattern bytes and evicted text bytes. A bin matches when both are equal.
    logic [DIFF_W-1:0]        r_plus_mem  [ALPHABET_SIZE];
    logic [DIFF_W-1:0]        r_minus_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_plus_vld;
    logic [ALPHABET_SIZE-1:0] r_minus_vld;

    t_item_ctl          r_s2_ctl;
    logic [BIN_W-1:0]   r_s2_bin;
    logic [BIN_W-1:0]   r_s2_tail;
    logic [DIFF_W-1:0]  r_pb_rd, r_pt_rd, r_mb_rd, r_mt_rd;
    logic               r_pb_ok, r_pt_ok, r_mb_ok, r_mt_ok;

    logic               r_lw_clear;
    logic               r_lw_p_we;
    logic [BIN_W-1:0]   r_lw_p_addr;
    logic [DIFF_W-1:0]  r_lw_p_data;
    logic               r_lw_m_we;
    logic [BIN_W-1:0]   r_lw_m_addr;
    logic [DIFF_W-1:0]  r_lw_m_data;

    logic [MM_W-1:0]        r_mm, n_mm;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;

    logic [DIFF_W-1:0] pb, pt, mb, mt;
    logic [DIFF_W-1:0] db, dt, db_after, dt_after;
    logic              v;
    logic              same;
    logic              b_on, t_on;
    logic              inc_b, dec_b, inc_t, dec_t;
    logic [MM_W-1:0]   mm_upd;
    logic              match;
    logic              p_we, m_we;
    logic [BIN_W-1:0]  p_addr, m_addr;
    logic [DIFF_W-1:0] p_data, m_data;

    function automatic logic [DIFF_W-1:0] fwd(
        input logic              clr,
        input logic              we,
        input logic [BIN_W-1:0]  wa,
        input logic [DIFF_W-1:0] wd,
        input logic [BIN_W-1:0]  ra,
        input logic              ok,
        input logic [DIFF_W-1:0] rd
    );
        logic [DIFF_W-1:0] val;
        if (clr) begin
            val = '0;
        end else if (we && (wa == ra)) begin
            val = wd;
        end else if (ok) begin
            val = rd;
        end else begin
            val = '0;
        end
        return val;
    endfunction

    always_comb begin
        v  = r_s2_ctl.valid;
        pb = fwd(r_lw_clear, r_lw_p_we, r_lw_p_addr, r_lw_p_data, r_s2_bin, r_pb_ok, r_pb_rd);
        pt = fwd(r_lw_clear, r_lw_p_we, r_lw_p_addr, r_lw_p_data, r_s2_tail, r_pt_ok, r_pt_rd);
        mb = fwd(r_lw_clear, r_lw_m_we, r_lw_m_addr, r_lw_m_data, r_s2_bin, r_mb_ok, r_mb_rd);
        mt = fwd(r_lw_clear, r_lw_m_we, r_lw_m_addr, r_lw_m_data, r_s2_tail, r_mt_ok, r_mt_rd);
        db = pb - mb;
        dt = pt - mt;

        p_we   = v && r_s2_ctl.txt_add;
        p_addr = r_s2_bin;
        p_data = pb + DIFF_W'(1);
        m_we   = v && (r_s2_ctl.pat_add || (r_s2_ctl.txt_add && r_s2_ctl.evict));
        m_addr = r_s2_ctl.pat_add ? r_s2_bin : r_s2_tail;
        m_data = r_s2_ctl.pat_add ? (mb + DIFF_W'(1)) : (mt + DIFF_W'(1));

        // When the evicted byte equals the entering one, the bin's difference is left unchanged.
        same = r_s2_ctl.txt_add && r_s2_ctl.evict && (r_s2_bin == r_s2_tail);
        if (r_s2_ctl.pat_add) begin
            db_after = db - DIFF_W'(1);
        end else if (same) begin
            db_after = db;
        end else begin
            db_after = db + DIFF_W'(1);
        end
        dt_after = dt - DIFF_W'(1);

        b_on  = v && (r_s2_ctl.pat_add || r_s2_ctl.txt_add);
        t_on  = v && r_s2_ctl.txt_add && r_s2_ctl.evict && !same;
        inc_b = b_on && (db == '0) && (db_after != '0);
        dec_b = b_on && (db != '0) && (db_after == '0);
        inc_t = t_on && (dt == '0) && (dt_after != '0);
        dec_t = t_on && (dt != '0) && (dt_after == '0);
        mm_upd = r_mm + MM_W'(inc_b) + MM_W'(inc_t) - MM_W'(dec_b) - MM_W'(dec_t);

        if (v && r_s2_ctl.clear) begin
            n_mm = '0;
        end else if (b_on) begin
            n_mm = mm_upd;
        end else begin
            n_mm = r_mm;
        end

        match = v && r_s2_ctl.txt_add && r_s2_ctl.win_full && (mm_upd == '0);

        if (v && r_s2_ctl.clear) begin
            n_total = '0;
        end else if (match && (r_total != '1)) begin
            n_total = r_total + TOTAL_WIDTH'(1);
        end else begin
            n_total = r_total;
        end

        o_push                = v;
        o_result.match        = match;
        o_result.match_total  = RESULT_TOTAL_W'(n_total);
        o_result.pattern_full = v && r_s2_ctl.pat_full;
    end

    always_ff @(posedge i_clk) begin
        r_pb_rd <= r_plus_mem[i_bin];
        r_pt_rd <= r_plus_mem[i_tail_sym];
        r_mb_rd <= r_minus_mem[i_bin];
        r_mt_rd <= r_minus_mem[i_tail_sym];
        if (p_we) begin
            r_plus_mem[p_addr] <= p_data;
        end
        if (m_we) begin
            r_minus_mem[m_addr] <= m_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pb_ok     <= r_plus_vld[i_bin];
        r_pt_ok     <= r_plus_vld[i_tail_sym];
        r_mb_ok     <= r_minus_vld[i_bin];
        r_mt_ok     <= r_minus_vld[i_tail_sym];
        r_s2_bin    <= i_bin;
        r_s2_tail   <= i_tail_sym;
        r_lw_p_addr <= p_addr;
        r_lw_p_data <= p_data;
        r_lw_m_addr <= m_addr;
        r_lw_m_data <= m_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_vld  <= '0;
            r_minus_vld <= '0;
            r_s2_ctl    <= '0;
            r_lw_clear  <= 1'b0;
            r_lw_p_we   <= 1'b0;
            r_lw_m_we   <= 1'b0;
            r_mm        <= '0;
            r_total     <= '0;
        end else begin
            r_s2_ctl   <= i_ctl;
            r_lw_clear <= v && r_s2_ctl.clear;
            r_lw_p_we  <= p_we;
            r_lw_m_we  <= m_we;
            r_mm       <= n_mm;
            r_total    <= n_total;
            if (v && r_s2_ctl.clear) begin
                r_plus_vld  <= '0;
                r_minus_vld <= '0;
            end else begin
                if (p_we) begin
                    r_plus_vld[p_addr] <= 1'b1;
                end
                if (m_we) begin
                    r_minus_vld[m_addr] <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- sv/awm_outq.sv -----
// Result queue of the anagram window matcher with a credit count of items in flight.
// Input ready is granted only while every accepted item has a queue slot waiting.
// Depends on awm_pkg.
module awm_outq
    import awm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_result o_result
);

    t_result              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp, r_rp;
    logic [Q_CNT_W-1:0]   r_qn, n_qn;
    logic [Q_CNT_W-1:0]   r_credit, n_credit;
    logic                 pop;

    always_comb begin
        o_in_ready  = (r_credit < Q_CNT_W'(Q_DEPTH));
        o_out_valid = (r_qn != '0);
        o_result    = r_q[r_rp];
        pop         = o_out_valid && i_out_ready;
        n_credit    = r_credit + Q_CNT_W'(i_take) - Q_CNT_W'(pop);
        n_qn        = r_qn + Q_CNT_W'(i_push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_qn     <= '0;
            r_credit <= '0;
        end else begin
            r_qn     <= n_qn;
            r_credit <= n_credit;
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_result;
        end
    end

endmodule
